// ----- rtl/sprite_frame_sequencer_defines.svh -----
// Assertion macros for the sprite frame sequencer.
// Used by the top level only; no other dependencies.
`ifndef SPRITE_FRAME_SEQUENCER_DEFINES_SVH
`define SPRITE_FRAME_SEQUENCER_DEFINES_SVH
`ifndef SYNTH
// Implication in the same cycle
`define SFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication in the next cycle
`define SFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define SFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/sfs_pkg.sv -----
// Shared types, codes and helper functions of the sprite frame sequencer.
// No dependencies.
`timescale 1ns / 1ps
package sfs_pkg;

    // request codes
    localparam logic [2:0] REQ_LOAD   = 3'd0;
    localparam logic [2:0] REQ_START  = 3'd1;
    localparam logic [2:0] REQ_TICK   = 3'd2;
    localparam logic [2:0] REQ_PAUSE  = 3'd3;
    localparam logic [2:0] REQ_RESUME = 3'd4;
    localparam logic [2:0] REQ_QOFS   = 3'd5;
    localparam logic [2:0] REQ_QSINCE = 3'd6;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_COUNT = 2'd0;
    localparam logic [1:0] CFG_LOOP_FIRST  = 2'd1;
    localparam logic [1:0] CFG_TOTAL_LEN   = 2'd2;

    localparam logic signed [15:0] HOLD_TICKS = -16'sd1;

    // width of the offset walk accumulator
    localparam int T_W = 40;

    // table read address select
    localparam logic [1:0] RD_SUM  = 2'd0;
    localparam logic [1:0] RD_POS  = 2'd1;
    localparam logic [1:0] RD_WALK = 2'd2;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [6:0]         frame_index;
        logic signed [15:0] frame_ticks;
        logic signed [15:0] time_offset;
    } t_req;

    typedef struct packed {
        logic [6:0]         current_frame;
        logic [31:0]        ticks_in_frame;
        logic [31:0]        ticks_overall;
        logic signed [31:0] ticks_remaining;
        logic               frame_starting;
        logic [6:0]         query_frame;
        logic signed [31:0] query_ticks;
        logic               walk_overflow;
    } t_res;

    typedef struct packed {
        logic       capture;
        logic       apply_misc;
        logic       sum_setup;
        logic       sum_acc;
        logic       sum_end;
        logic       tick_upd;
        logic       walk_init;
        logic       walk_step;
        logic       finish;
        logic [1:0] rd_sel;
    } t_cmd;

    typedef struct packed {
        logic [2:0] req_type;
        logic       paused;
        logic       sum_done;
        logic       tick_wrap;
        logic       walk_done;
    } t_sts;

    // saturate a 34-bit signed value to 32 signed bits
    function automatic logic [31:0] sat_s32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v < -34'sh0_8000_0000) begin
            r = 32'h8000_0000;
        end else if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'h7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/sfs_ctrl.sv -----
// Controller of the sprite frame sequencer: one-hot state machine.
// Depends on sfs_pkg; drives t_cmd to the datapath and reads t_sts back.
`timescale 1ns / 1ps
module sfs_ctrl import sfs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_DISPATCH  = 12'b0000_0000_0010,
        S_SUM_CHK   = 12'b0000_0000_0100,
        S_SUM_ACC   = 12'b0000_0000_1000,
        S_SUM_END   = 12'b0000_0001_0000,
        S_TICK_RD   = 12'b0000_0010_0000,
        S_TICK_UPD  = 12'b0000_0100_0000,
        S_WALK_RD0  = 12'b0000_1000_0000,
        S_WALK_INIT = 12'b0001_0000_0000,
        S_WALK_RD   = 12'b0010_0000_0000,
        S_WALK_STEP = 12'b0100_0000_0000,
        S_FINISH    = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

    // sequence each request through the datapath
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_SUM;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.req_type)
                    REQ_START, REQ_QSINCE: begin
                        o_cmd.sum_setup = 1'b1;
                        n_state = S_SUM_CHK;
                    end
                    REQ_TICK: begin
                        n_state = i_sts.paused ? S_FINISH : S_TICK_RD;
                    end
                    REQ_QOFS: begin
                        n_state = S_WALK_RD0;
                    end
                    default: begin
                        o_cmd.apply_misc = 1'b1;
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_SUM_CHK: begin
                o_cmd.rd_sel = RD_SUM;
                n_state = i_sts.sum_done ? S_SUM_END : S_SUM_ACC;
            end
            S_SUM_ACC: begin
                o_cmd.sum_acc = 1'b1;
                n_state = S_SUM_CHK;
            end
            S_SUM_END: begin
                o_cmd.sum_end = 1'b1;
                n_state = S_FINISH;
            end
            S_TICK_RD: begin
                o_cmd.rd_sel = RD_POS;
                n_state = S_TICK_UPD;
            end
            S_TICK_UPD: begin
                o_cmd.tick_upd = 1'b1;
                if (i_sts.tick_wrap) begin
                    o_cmd.sum_setup = 1'b1;
                    n_state = S_SUM_CHK;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_WALK_RD0: begin
                o_cmd.rd_sel = RD_POS;
                n_state = S_WALK_INIT;
            end
            S_WALK_INIT: begin
                o_cmd.walk_init = 1'b1;
                n_state = S_WALK_RD;
            end
            S_WALK_RD: begin
                o_cmd.rd_sel = RD_WALK;
                n_state = S_WALK_STEP;
            end
            S_WALK_STEP: begin
                o_cmd.walk_step = 1'b1;
                n_state = i_sts.walk_done ? S_FINISH : S_WALK_RD;
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/sfs_datapath.sv -----
// Datapath of the sprite frame sequencer: duration table, timeline state,
// summing and offset walk engine, result register. Depends on sfs_pkg.
`timescale 1ns / 1ps
module sfs_datapath import sfs_pkg::*; #(
    parameter int MAX_FRAMES = 64,
    parameter int WALK_LIMIT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data,
    input  t_req        i_req,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_res_valid,
    output t_res        o_res
);

    localparam int PW  = $clog2(MAX_FRAMES);
    localparam int NW  = $clog2(MAX_FRAMES + 1);
    localparam int SCW = $clog2(WALK_LIMIT + 1);

    // configuration and timeline state
    logic [6:0]          r_fc;
    logic [5:0]          r_loop;
    logic [30:0]         r_tl;
    logic [PW-1:0]       r_pos;
    logic [31:0]         r_fe;
    logic [31:0]         r_te;
    logic                r_paused;
    logic                r_res_valid;

    // request and engine registers
    t_req                r_req;
    logic [15:0]         mem_tbl [MAX_FRAMES];
    logic signed [15:0]  r_rd;
    logic signed [31:0]  r_acc;
    logic [PW-1:0]       r_cnt;
    logic [PW-1:0]       r_target;
    logic signed [T_W-1:0] r_t;
    logic [PW-1:0]       r_cur;
    logic [SCW-1:0]      r_steps;
    logic [6:0]          r_qframe;
    logic [31:0]         r_qticks;
    logic                r_ovf;
    t_res                r_res, n_res;

    logic [NW-1:0]       w_n;
    logic [PW-1:0]       w_last, w_pos, w_loop, w_start_s, w_since_k, w_addr;
    logic                w_load_ok;
    logic [31:0]         w_fe1, w_te1;
    logic signed [32:0]  w_d33;
    logic                w_expire, w_wrap;
    logic                w_fwd, w_limit, w_found;
    logic signed [T_W-1:0] w_d_t, w_fe_t, w_t_init;
    logic [PW-1:0]       w_cur_fwd, w_cur_bwd;
    logic [31:0]         w_acc_sat;

    // effective count, position, loop start
    always_comb begin
        if (r_fc == 7'd0) begin
            w_n = NW'(1);
        end else if (32'(r_fc) > 32'(MAX_FRAMES)) begin
            w_n = NW'(MAX_FRAMES);
        end else begin
            w_n = NW'(r_fc);
        end
        w_last    = PW'(32'(w_n) - 32'd1);
        w_pos     = (32'(r_pos) >= 32'(w_n)) ? w_last : r_pos;
        w_loop    = (32'(r_loop) >= 32'(w_n)) ? w_last : PW'(r_loop);
        w_start_s = (32'(r_req.frame_index) >= 32'(w_n)) ? w_last : PW'(r_req.frame_index);
        if (r_req.frame_index == 7'd0) begin
            w_since_k = '0;
        end else if (32'(r_req.frame_index) - 32'd1 >= 32'(w_n)) begin
            w_since_k = w_last;
        end else begin
            w_since_k = PW'(32'(r_req.frame_index) - 32'd1);
        end
        w_load_ok = (32'(r_req.frame_index) < 32'(MAX_FRAMES));
    end

    // table read address
    always_comb begin
        case (i_cmd.rd_sel)
            RD_SUM:  w_addr = r_cnt;
            RD_POS:  w_addr = w_pos;
            RD_WALK: w_addr = r_cur;
            default: w_addr = r_cnt;
        endcase
    end

    // tick arithmetic
    always_comb begin
        w_fe1    = (r_fe == 32'hFFFF_FFFF) ? r_fe : r_fe + 32'd1;
        w_te1    = (r_te == 32'hFFFF_FFFF) ? r_te : r_te + 32'd1;
        w_d33    = 33'(r_rd);
        w_expire = (r_rd != HOLD_TICKS) && ($signed({1'b0, w_fe1}) >= w_d33);
        w_wrap   = w_expire && (32'(w_pos) + 32'd1 >= 32'(w_n));
        w_acc_sat = (r_acc < 0) ? 32'd0 : 32'(r_acc);
    end

    // offset walk arithmetic
    always_comb begin
        w_fwd    = (r_req.time_offset > 16'sd0);
        w_d_t    = T_W'(r_rd);
        w_fe_t   = $signed({{(T_W-32){1'b0}}, r_fe});
        if (w_fwd) begin
            w_t_init = T_W'(r_req.time_offset) + w_fe_t;
        end else begin
            w_t_init = -T_W'(r_req.time_offset) + w_d_t - T_W'(1) - w_fe_t;
        end
        w_limit  = (r_steps == SCW'(WALK_LIMIT));
        w_found  = (r_t < w_d_t) || (r_rd == HOLD_TICKS);
        w_cur_fwd = (32'(r_cur) + 32'd1 >= 32'(w_n)) ? w_loop : PW'(32'(r_cur) + 32'd1);
        w_cur_bwd = ((r_cur == '0) || (r_cur <= w_loop)) ? w_last
                                                          : PW'(32'(r_cur) - 32'd1);
    end

    always_comb begin
        o_sts.req_type  = r_req.req_type;
        o_sts.paused    = r_paused;
        o_sts.sum_done  = (r_cnt == r_target);
        o_sts.tick_wrap = w_wrap;
        o_sts.walk_done = w_limit || w_found;
    end

    // duration table: write on load, registered read every cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply_misc && (r_req.req_type == REQ_LOAD) && w_load_ok) begin
            mem_tbl[PW'(r_req.frame_index)] <= r_req.frame_ticks;
        end
        r_rd <= $signed(mem_tbl[w_addr]);
    end

    // configuration and timeline state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc        <= 7'd1;
            r_loop      <= 6'd0;
            r_tl        <= 31'd0;
            r_pos       <= '0;
            r_fe        <= 32'd0;
            r_te        <= 32'd0;
            r_paused    <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.finish;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_COUNT: r_fc   <= i_cfg_data[6:0];
                    CFG_LOOP_FIRST:  r_loop <= i_cfg_data[5:0];
                    CFG_TOTAL_LEN:   r_tl   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.apply_misc) begin
                if (r_req.req_type == REQ_PAUSE) begin
                    r_paused <= 1'b1;
                end else if (r_req.req_type == REQ_RESUME) begin
                    r_paused <= 1'b0;
                end
            end
            // advance on tick, wrap sets the start time later
            if (i_cmd.tick_upd) begin
                r_te <= w_te1;
                if (w_expire) begin
                    r_fe  <= 32'd0;
                    r_pos <= w_wrap ? w_loop : PW'(32'(w_pos) + 32'd1);
                end else begin
                    r_fe <= w_fe1;
                end
            end
            if (i_cmd.sum_end) begin
                if (r_req.req_type == REQ_START) begin
                    r_te  <= w_acc_sat;
                    r_pos <= r_target;
                    r_fe  <= 32'd0;
                end else if (r_req.req_type == REQ_TICK) begin
                    r_te <= w_acc_sat;
                end
            end
        end
    end

    // request capture, summing and walk engine
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req    <= i_req;
            r_qframe <= 7'd0;
            r_qticks <= 32'd0;
            r_ovf    <= 1'b0;
        end
        if (i_cmd.sum_setup) begin
            r_cnt <= '0;
            r_acc <= '0;
            case (r_req.req_type)
                REQ_START:  r_target <= w_start_s;
                REQ_QSINCE: r_target <= w_since_k;
                default:    r_target <= w_loop;
            endcase
        end
        if (i_cmd.sum_acc) begin
            r_acc <= r_acc + 32'(r_rd);
            r_cnt <= PW'(32'(r_cnt) + 32'd1);
        end
        if (i_cmd.sum_end && (r_req.req_type == REQ_QSINCE)) begin
            r_qticks <= sat_s32($signed({2'b00, r_te}) - 34'(r_acc));
        end
        if (i_cmd.walk_init) begin
            r_t     <= w_t_init;
            r_cur   <= w_pos;
            r_steps <= '0;
        end
        if (i_cmd.walk_step) begin
            if (w_limit) begin
                r_ovf <= 1'b1;
            end else if (w_found) begin
                r_qframe <= 7'(32'(r_cur) + 32'd1);
            end else begin
                r_t     <= r_t - w_d_t;
                r_cur   <= w_fwd ? w_cur_fwd : w_cur_bwd;
                r_steps <= r_steps + SCW'(1);
            end
        end
        if (i_cmd.finish) begin
            r_res <= n_res;
        end
    end

    // assemble the result beat
    always_comb begin
        n_res.current_frame   = 7'(32'(w_pos) + 32'd1);
        n_res.ticks_in_frame  = r_fe;
        n_res.ticks_overall   = r_te;
        n_res.ticks_remaining = sat_s32($signed({3'b000, r_tl}) - $signed({2'b00, r_te})
                                        - 34'sd1);
        n_res.frame_starting  = !r_paused && (r_fe == 32'd0);
        n_res.query_frame     = r_qframe;
        n_res.query_ticks     = r_qticks;
        n_res.walk_overflow   = r_ovf;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ----- rtl/sprite_frame_sequencer.sv -----
// Sprite frame sequencer, top level: controller plus datapath.
// Depends on sfs_pkg, sfs_ctrl, sfs_datapath and the defines header.
//
// Usage: drive i_req and raise start while busy is low; that beat is taken
// and busy goes high on the next cycle. One result beat follows for every
// request: o_res_valid is high for exactly one cycle with o_res, and the
// receiver must take it then, as it cannot stall the block. busy drops in the
// same cycle as the strobe, so a new request may start right then.
// Each request runs through the controller states up to S_FINISH: pause,
// resume, load, unknown requests and a tick while paused need no table read;
// a tick reads the duration of the current frame and, on a wrap, sums each
// frame before the loop start; start and the time-since query sum table
// entries; the offset query walks one frame per step, at most WALK_LIMIT + 1
// steps, the last of which only flags the cap. The duration table has a
// single read port.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 frame count, 1 loop start, 2 total length) while busy is low.
// Reset (synchronous, active low) clears timeline state and sets the frame
// count to 1; the duration table holds no defined value until loaded.
`timescale 1ns / 1ps
`include "sprite_frame_sequencer_defines.svh"
module sprite_frame_sequencer import sfs_pkg::*; #(
    parameter int MAX_FRAMES = 64,
    parameter int WALK_LIMIT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data,
    output logic        o_res_valid,
    output t_res        o_res
);

    t_cmd w_cmd;
    t_sts w_sts;

    sfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    sfs_datapath #(
        .MAX_FRAMES (MAX_FRAMES),
        .WALK_LIMIT (WALK_LIMIT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // result beat only arrives as the block goes idle
    `SFS_ASSERT_NOW(a_res_idle, i_clk, i_rst_n, o_res_valid, !busy, "result while busy")
    // an accepted request always makes the block busy
    `SFS_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, start && !busy, busy, "request dropped")
    // never two result beats back to back
    `SFS_ASSERT_NEXT(a_one_beat, i_clk, i_rst_n, o_res_valid, !o_res_valid, "double beat")
    // every finished request gives a beat
    `SFS_ASSERT_NOW(a_fall_res, i_clk, i_rst_n, $fell(busy), o_res_valid, "lost result")

endmodule
